// File: rtl/lcdtt_pkg.sv
package lcdtt_pkg;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [3:0] REG_DIV  = 4'd0;
  localparam logic [3:0] REG_TIMA = 4'd1;
  localparam logic [3:0] REG_TMA  = 4'd2;
  localparam logic [3:0] REG_TAC  = 4'd3;
  localparam logic [3:0] REG_IF   = 4'd4;
  localparam logic [3:0] REG_LCDC = 4'd5;
  localparam logic [3:0] REG_STAT = 4'd6;
  localparam logic [3:0] REG_LY   = 4'd7;
  localparam logic [3:0] REG_LYC  = 4'd8;

  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_DRAW   = 2'd3;

  localparam logic [1:0] TAC_SEL_BIT9  = 2'd0;
  localparam logic [1:0] TAC_SEL_COUNT = 2'd1;
  localparam logic [1:0] TAC_SEL_BIT5  = 2'd2;
  localparam logic [1:0] TAC_SEL_BIT7  = 2'd3;

  localparam logic [7:0] LINE_VBLANK = 8'd144;
  localparam logic [7:0] LINE_LAST   = 8'd153;

  localparam logic [9:0] CYC_OAM          = 10'd80;
  localparam logic [9:0] CYC_DRAW         = 10'd168;
  localparam logic [9:0] CYC_HBLANK       = 10'd208;
  localparam logic [9:0] CYC_VBLANK_EXTRA = 10'd376;
  localparam logic [9:0] CYC_LINE         = 10'd456;

  localparam logic [15:0] COUNTER_RESET = 16'hAC00;
  localparam logic [7:0]  TAC_RESET     = 8'hF8;
  localparam logic [7:0]  TAC_FIXED     = 8'hF8;
  localparam logic [7:0]  IRQ_RESET     = 8'hE0;
  localparam logic [7:0]  IRQ_FIXED     = 8'hE0;
  localparam logic [7:0]  LCDC_RESET    = 8'h91;
  localparam logic [7:0]  STAT_RESET    = 8'h82;
  localparam logic [15:0] MCL_RESET     = 16'd80;
  localparam logic [7:0]  READ_UNUSED   = 8'hFF;

  typedef struct packed {
    logic [7:0]  stat;
    logic [7:0]  line;
    logic [15:0] mcl;
  } disp_state_t;

  typedef struct packed {
    logic [15:0] counter;
    logic [7:0]  tima;
    logic        ovf;
  } timer_state_t;

endpackage

// File: rtl/lcd_timing_and_timer_unit_top.sv
// Display mode sequencer and divider/timer unit with one input channel and one
// result channel, both using valid/ready handshakes.
// Each input transfer carries an action (tick, register write or register read),
// a register select, a write byte and a count of elapsed machine cycles.
// Every input transfer produces exactly one result transfer with the read byte,
// the interrupt flag byte, the display mode, the current line and an hblank flag.
// An item is captured in an input register and its result is computed in one
// pass of combinational logic into the output register, from which the result
// is offered on the result channel.
// A new item is accepted in every cycle while the receiver takes results; the
// throughput is then one item per cycle, set by the single register update
// between the input and output registers. When the receiver stalls, the output
// register holds its result, the input register still takes one more item, and
// then ready drops until the result is taken.
// Reset clears both stages and loads the registers with their power-on values:
// the display starts in OAM mode on line 0 and the divider at 0xAC00.
module lcd_timing_and_timer_unit_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [3:0] reg_select_i,
  input  logic [7:0] write_value_i,
  input  logic [7:0] elapsed_cycles_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_value_o,
  output logic [7:0] irq_flags_o,
  output logic [1:0] lcd_mode_o,
  output logic [7:0] line_number_o,
  output logic       hblank_started_o
);

  logic       in_valid_q;
  logic [1:0] act_q;
  logic [3:0] sel_q;
  logic [7:0] wval_q;
  logic [7:0] cyc_q;
  logic       advance;

  lcdtt_pkg::timer_state_t tmr_q, tmr_d, tmr_nx;
  lcdtt_pkg::disp_state_t  disp_q, disp_d, disp_nx;
  logic [7:0] tma_q, tma_d;
  logic [7:0] tac_q, tac_d;
  logic [7:0] irq_q, irq_d;
  logic [7:0] lcdc_q, lcdc_d;
  logic [7:0] lyc_q, lyc_d;
  logic [7:0] disp_irq, tmr_irq;
  logic       disp_hb;
  logic [7:0] rval_d;
  logic       hb_d;

  logic       out_valid_q;
  logic [7:0] rval_q;
  logic [7:0] irqo_q;
  logic [1:0] mode_q;
  logic [7:0] line_q;
  logic       hb_q;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  lcdtt_display u_display (
    .cur_i    (disp_q),
    .lyc_i    (lyc_q),
    .cycles_i (cyc_q),
    .nxt_o    (disp_nx),
    .irq_set_o(disp_irq),
    .hblank_o (disp_hb)
  );

  lcdtt_timer u_timer (
    .cur_i    (tmr_q),
    .tac_i    (tac_q),
    .tma_i    (tma_q),
    .cycles_i (cyc_q),
    .nxt_o    (tmr_nx),
    .irq_set_o(tmr_irq)
  );

  always_comb begin
    tmr_d  = tmr_q;
    disp_d = disp_q;
    tma_d  = tma_q;
    tac_d  = tac_q;
    irq_d  = irq_q;
    lcdc_d = lcdc_q;
    lyc_d  = lyc_q;
    rval_d = 8'd0;
    hb_d   = 1'b0;
    case (act_q)
      lcdtt_pkg::ACT_TICK: begin
        if (lcdc_q[7]) begin
          disp_d = disp_nx;
          hb_d   = disp_hb;
          irq_d  = irq_d | disp_irq;
        end
        tmr_d = tmr_nx;
        irq_d = irq_d | tmr_irq;
      end
      lcdtt_pkg::ACT_WRITE: begin
        case (sel_q)
          lcdtt_pkg::REG_DIV:  tmr_d.counter = 16'd0;
          lcdtt_pkg::REG_TIMA: tmr_d.tima = wval_q;
          lcdtt_pkg::REG_TMA:  tma_d = wval_q;
          lcdtt_pkg::REG_TAC:  tac_d = lcdtt_pkg::TAC_FIXED | wval_q;
          lcdtt_pkg::REG_IF:   irq_d = lcdtt_pkg::IRQ_FIXED | wval_q;
          lcdtt_pkg::REG_LCDC: begin
            lcdc_d = wval_q;
            if (!wval_q[7]) begin
              disp_d.stat[1:0] = lcdtt_pkg::MODE_HBLANK;
              disp_d.line      = 8'd0;
              disp_d.mcl       = lcdtt_pkg::MCL_RESET;
            end
          end
          lcdtt_pkg::REG_STAT: disp_d.stat = (disp_q.stat & 8'h83) | (wval_q & 8'hFC);
          lcdtt_pkg::REG_LYC: begin
            lyc_d = wval_q;
            if (disp_q.line == wval_q) begin
              disp_d.stat[2] = 1'b1;
              irq_d[1]       = irq_q[1] | disp_q.stat[6];
            end
          end
          default: ;
        endcase
      end
      lcdtt_pkg::ACT_READ: begin
        case (sel_q)
          lcdtt_pkg::REG_DIV:  rval_d = tmr_q.counter[15:8];
          lcdtt_pkg::REG_TIMA: rval_d = tmr_q.tima;
          lcdtt_pkg::REG_TMA:  rval_d = tma_q;
          lcdtt_pkg::REG_TAC:  rval_d = tac_q;
          lcdtt_pkg::REG_IF:   rval_d = irq_q;
          lcdtt_pkg::REG_LCDC: rval_d = lcdc_q;
          lcdtt_pkg::REG_STAT: rval_d = disp_q.stat;
          lcdtt_pkg::REG_LY:   rval_d = disp_q.line;
          lcdtt_pkg::REG_LYC:  rval_d = lyc_q;
          default:             rval_d = lcdtt_pkg::READ_UNUSED;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      tmr_q.counter <= lcdtt_pkg::COUNTER_RESET;
      tmr_q.tima   <= 8'd0;
      tmr_q.ovf    <= 1'b0;
      disp_q.stat  <= lcdtt_pkg::STAT_RESET;
      disp_q.line  <= 8'd0;
      disp_q.mcl   <= lcdtt_pkg::MCL_RESET;
      tma_q        <= 8'd0;
      tac_q        <= lcdtt_pkg::TAC_RESET;
      irq_q        <= lcdtt_pkg::IRQ_RESET;
      lcdc_q       <= lcdtt_pkg::LCDC_RESET;
      lyc_q        <= 8'd0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        tmr_q       <= tmr_d;
        disp_q      <= disp_d;
        tma_q       <= tma_d;
        tac_q       <= tac_d;
        irq_q       <= irq_d;
        lcdc_q      <= lcdc_d;
        lyc_q       <= lyc_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q  <= action_i;
      sel_q  <= reg_select_i;
      wval_q <= write_value_i;
      cyc_q  <= elapsed_cycles_i;
    end
    if (advance) begin
      rval_q <= rval_d;
      irqo_q <= irq_d;
      mode_q <= disp_d.stat[1:0];
      line_q <= disp_d.line;
      hb_q   <= hb_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_value_o     = rval_q;
  assign irq_flags_o      = irqo_q;
  assign lcd_mode_o       = mode_q;
  assign line_number_o    = line_q;
  assign hblank_started_o = hb_q;

endmodule

// File: rtl/lcdtt_display.sv
module lcdtt_display (
  input  lcdtt_pkg::disp_state_t cur_i,
  input  logic [7:0]             lyc_i,
  input  logic [7:0]             cycles_i,
  output lcdtt_pkg::disp_state_t nxt_o,
  output logic [7:0]             irq_set_o,
  output logic                   hblank_o
);

  logic signed [16:0] diff;
  logic [15:0]        sat;
  logic               expired;
  logic [1:0]         mode;
  logic [7:0]         line;
  logic [9:0]         add;
  logic [7:0]         stat;
  logic [7:0]         irq;
  logic               hb;

  always_comb begin
    diff    = $signed({cur_i.mcl[15], cur_i.mcl}) - $signed({9'd0, cycles_i});
    sat     = (diff[16] && !diff[15]) ? 16'h8000 : diff[15:0];
    expired = sat[15] || (sat == 16'd0);
    mode    = cur_i.stat[1:0];
    line    = cur_i.line;
    add     = 10'd0;
    stat    = cur_i.stat;
    irq     = 8'd0;
    hb      = 1'b0;
    if (expired) begin
      if ((line < lcdtt_pkg::LINE_VBLANK) && (mode != lcdtt_pkg::MODE_VBLANK)) begin
        case (mode)
          lcdtt_pkg::MODE_HBLANK: begin
            mode = lcdtt_pkg::MODE_OAM;
            add  = lcdtt_pkg::CYC_OAM;
          end
          lcdtt_pkg::MODE_OAM: begin
            mode = lcdtt_pkg::MODE_DRAW;
            add  = lcdtt_pkg::CYC_DRAW;
          end
          default: begin
            mode = lcdtt_pkg::MODE_HBLANK;
            add  = lcdtt_pkg::CYC_HBLANK;
          end
        endcase
        if (mode == lcdtt_pkg::MODE_HBLANK) begin
          irq[1] = irq[1] | cur_i.stat[3];
          hb     = 1'b1;
        end
        if (mode == lcdtt_pkg::MODE_OAM) begin
          line   = line + 8'd1;
          irq[1] = irq[1] | cur_i.stat[5];
        end
        if (line == lcdtt_pkg::LINE_VBLANK) begin
          mode   = lcdtt_pkg::MODE_VBLANK;
          add    = add + lcdtt_pkg::CYC_VBLANK_EXTRA;
          irq[0] = 1'b1;
          irq[1] = irq[1] | cur_i.stat[4];
        end
      end else if (line >= lcdtt_pkg::LINE_VBLANK) begin
        line = line + 8'd1;
        add  = lcdtt_pkg::CYC_LINE;
        if (line == lcdtt_pkg::LINE_LAST) begin
          irq[1] = irq[1] | ((lyc_i == lcdtt_pkg::LINE_LAST) & cur_i.stat[6]);
          line   = 8'd0;
        end
      end else if (line == 8'd0) begin
        mode   = lcdtt_pkg::MODE_OAM;
        irq[1] = irq[1] | cur_i.stat[5];
        add    = lcdtt_pkg::CYC_OAM;
      end
      if ((line == lyc_i) &&
          ((mode == lcdtt_pkg::MODE_OAM) || (mode == lcdtt_pkg::MODE_VBLANK))) begin
        if ((line != 8'd0) || (mode == lcdtt_pkg::MODE_VBLANK)) begin
          stat[2] = 1'b1;
          irq[1]  = irq[1] | cur_i.stat[6];
        end
      end else begin
        stat[2] = 1'b0;
      end
    end
    stat[1:0]  = mode;
    nxt_o.stat = stat;
    nxt_o.line = line;
    nxt_o.mcl  = sat + {6'd0, add};
    irq_set_o  = irq;
    hblank_o   = hb;
  end

endmodule

// File: rtl/lcdtt_timer.sv
module lcdtt_timer (
  input  lcdtt_pkg::timer_state_t cur_i,
  input  logic [7:0]              tac_i,
  input  logic [7:0]              tma_i,
  input  logic [7:0]              cycles_i,
  output lcdtt_pkg::timer_state_t nxt_o,
  output logic [7:0]              irq_set_o
);

  logic [16:0] sum;
  logic [12:0] steps;
  logic [4:0]  inc;
  logic [7:0]  base;
  logic [8:0]  bumped;
  logic        fall;

  always_comb begin
    sum       = {1'b0, cur_i.counter} + {9'd0, cycles_i};
    steps     = sum[16:4] - {1'b0, cur_i.counter[15:4]};
    nxt_o     = cur_i;
    irq_set_o = 8'd0;
    nxt_o.counter = sum[15:0];
    case (tac_i[1:0])
      lcdtt_pkg::TAC_SEL_BIT9: fall = cur_i.counter[9] && !sum[9];
      lcdtt_pkg::TAC_SEL_BIT5: fall = cur_i.counter[5] && !sum[5];
      lcdtt_pkg::TAC_SEL_BIT7: fall = cur_i.counter[7] && !sum[7];
      default:                 fall = 1'b0;
    endcase
    inc    = (tac_i[1:0] == lcdtt_pkg::TAC_SEL_COUNT) ? steps[4:0] : {4'd0, fall};
    base   = cur_i.ovf ? tma_i : cur_i.tima;
    bumped = {1'b0, base} + {4'd0, inc};
    if (tac_i[2]) begin
      irq_set_o[2] = cur_i.ovf;
      nxt_o.tima   = bumped[7:0];
      nxt_o.ovf    = bumped[8];
    end
  end

endmodule

// File: rtl/lcdtt_checker.sv
module lcdtt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] read_value_o,
  input logic [7:0] irq_flags_o,
  input logic [1:0] lcd_mode_o,
  input logic [7:0] line_number_o,
  input logic       hblank_started_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_value_o) &&
      $stable(irq_flags_o) && $stable(line_number_o))
    else $error("Stalled result changed before its transfer.");

  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> line_number_o <= lcdtt_pkg::LINE_LAST)
    else $error("Line number beyond the last vblank line.");

  a_vblank_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && lcd_mode_o == lcdtt_pkg::MODE_VBLANK |->
      line_number_o >= lcdtt_pkg::LINE_VBLANK || line_number_o == 8'd0)
    else $error("Vblank mode reported on a visible line.");

  a_hblank_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hblank_started_o |-> lcd_mode_o == lcdtt_pkg::MODE_HBLANK)
    else $error("Hblank entry reported outside hblank mode.");

  a_irq_fixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> irq_flags_o[7:5] == 3'b111)
    else $error("Unused interrupt flag bits are not set.");

endmodule

bind lcd_timing_and_timer_unit_top lcdtt_checker u_lcdtt_checker (.*);

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam logic [3:0] REG_UNUSED_LO = 4'd9;
  localparam logic [3:0] REG_UNUSED_HI = 4'd15;

  localparam int IF_VBLANK = 0;
  localparam int IF_STAT   = 1;
  localparam int IF_TIMER  = 2;

  localparam int STAT_MATCH   = 2;
  localparam int STAT_IE_HBL  = 3;
  localparam int STAT_IE_VBL  = 4;
  localparam int STAT_IE_OAM  = 5;
  localparam int STAT_IE_LYC  = 6;

  localparam int TAC_ENABLE   = 2;
  localparam int LCDC_ENABLE  = 7;
  localparam int NO_IDLE_TAIL = 80;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] sel;
    logic [7:0] wval;
    logic [7:0] cyc;
  } bus_item_t;

  typedef struct packed {
    logic [7:0] rval;
    logic [7:0] irq;
    logic [1:0] mode;
    logic [7:0] line;
    logic       hb;
  } lcd_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] action = lcdtt_pkg::ACT_TICK;
  logic [3:0] reg_select = lcdtt_pkg::REG_DIV;
  logic [7:0] write_value = 8'h00;
  logic [7:0] elapsed_cycles = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] read_value;
  logic [7:0] irq_flags;
  logic [1:0] lcd_mode;
  logic [7:0] line_number;
  logic       hblank_started;

  bus_item_t   pending_items[$];
  lcd_result_t expected_results[$];
  int          accepted_items = 0;
  int          mismatches = 0;
  int          send_gap = 0;
  int          hold_left = 0;
  logic        long_hold = 1'b0;

  logic [15:0] div_count;
  logic [7:0]  tima_val;
  logic [7:0]  tma_val;
  logic [7:0]  tac_val;
  logic        reload_pending;
  logic [7:0]  if_val;
  logic [7:0]  lcdc_val;
  logic [7:0]  stat_val;
  logic [7:0]  ly_val;
  logic [7:0]  lyc_val;
  int          mode_budget;

  lcd_timing_and_timer_unit_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .action_i         (action),
    .reg_select_i     (reg_select),
    .write_value_i    (write_value),
    .elapsed_cycles_i (elapsed_cycles),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .read_value_o     (read_value),
    .irq_flags_o      (irq_flags),
    .lcd_mode_o       (lcd_mode),
    .line_number_o    (line_number),
    .hblank_started_o (hblank_started)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic step_display(int cyc);
    logic [1:0] md;
    logic       hb;
    md = stat_val[1:0];
    hb = 1'b0;
    mode_budget = mode_budget - cyc;
    if (mode_budget < -32768) mode_budget = -32768;
    if (mode_budget <= 0) begin
      if (ly_val < lcdtt_pkg::LINE_VBLANK && md != lcdtt_pkg::MODE_VBLANK) begin
        if (md == lcdtt_pkg::MODE_HBLANK) begin
          md = lcdtt_pkg::MODE_OAM;
          mode_budget += int'(lcdtt_pkg::CYC_OAM);
        end else if (md == lcdtt_pkg::MODE_OAM) begin
          md = lcdtt_pkg::MODE_DRAW;
          mode_budget += int'(lcdtt_pkg::CYC_DRAW);
        end else begin
          md = lcdtt_pkg::MODE_HBLANK;
          mode_budget += int'(lcdtt_pkg::CYC_HBLANK);
        end
        if (md == lcdtt_pkg::MODE_HBLANK) begin
          if (stat_val[STAT_IE_HBL]) if_val[IF_STAT] = 1'b1;
          hb = 1'b1;
        end
        if (md == lcdtt_pkg::MODE_OAM) begin
          ly_val = ly_val + 8'd1;
          if (stat_val[STAT_IE_OAM]) if_val[IF_STAT] = 1'b1;
        end
        if (ly_val == lcdtt_pkg::LINE_VBLANK) begin
          md = lcdtt_pkg::MODE_VBLANK;
          mode_budget += int'(lcdtt_pkg::CYC_VBLANK_EXTRA);
          if_val[IF_VBLANK] = 1'b1;
          if (stat_val[STAT_IE_VBL]) if_val[IF_STAT] = 1'b1;
        end
      end else if (ly_val >= lcdtt_pkg::LINE_VBLANK) begin
        ly_val = ly_val + 8'd1;
        mode_budget += int'(lcdtt_pkg::CYC_LINE);
        if (ly_val == lcdtt_pkg::LINE_LAST) begin
          if (ly_val == lyc_val && stat_val[STAT_IE_LYC]) if_val[IF_STAT] = 1'b1;
          ly_val = 8'd0;
        end
      end else if (ly_val == 8'd0) begin
        md = lcdtt_pkg::MODE_OAM;
        if (stat_val[STAT_IE_OAM]) if_val[IF_STAT] = 1'b1;
        mode_budget += int'(lcdtt_pkg::CYC_OAM);
      end
      if (ly_val == lyc_val &&
          (md == lcdtt_pkg::MODE_OAM || md == lcdtt_pkg::MODE_VBLANK)) begin
        if (ly_val != 8'd0 || md == lcdtt_pkg::MODE_VBLANK) begin
          stat_val[STAT_MATCH] = 1'b1;
          if (stat_val[STAT_IE_LYC]) if_val[IF_STAT] = 1'b1;
        end
      end else begin
        stat_val[STAT_MATCH] = 1'b0;
      end
    end
    stat_val[1:0] = md;
    return hb;
  endfunction

  function automatic void step_timer(int cyc);
    int          prev;
    int          sum;
    int          steps;
    logic [15:0] nxt;
    logic [15:0] tap;
    prev = int'(div_count);
    sum = prev + cyc;
    nxt = sum[15:0];
    div_count = nxt;
    if (!tac_val[TAC_ENABLE]) return;
    if (reload_pending) begin
      reload_pending = 1'b0;
      tima_val = tma_val;
      if_val[IF_TIMER] = 1'b1;
    end
    case (tac_val[1:0])
      lcdtt_pkg::TAC_SEL_BIT9: tap = 16'h0200;
      lcdtt_pkg::TAC_SEL_BIT5: tap = 16'h0020;
      lcdtt_pkg::TAC_SEL_BIT7: tap = 16'h0080;
      default:                 tap = 16'h0000;
    endcase
    steps = 0;
    if (tap == 16'h0000) steps = (sum >> 4) - (prev >> 4);
    else if ((prev[15:0] & tap) != 16'h0000 && (nxt & tap) == 16'h0000) steps = 1;
    for (int i = 0; i < steps; i++) begin
      tima_val = tima_val + 8'd1;
      if (tima_val == 8'd0) reload_pending = 1'b1;
    end
  endfunction

  function automatic lcd_result_t predict_result(bus_item_t it);
    lcd_result_t r;
    r.rval = 8'h00;
    r.hb = 1'b0;
    if (it.action == lcdtt_pkg::ACT_TICK) begin
      if (lcdc_val[LCDC_ENABLE]) r.hb = step_display(int'(it.cyc));
      step_timer(int'(it.cyc));
    end else if (it.action == lcdtt_pkg::ACT_WRITE) begin
      case (it.sel)
        lcdtt_pkg::REG_DIV:  div_count = 16'h0000;
        lcdtt_pkg::REG_TIMA: tima_val = it.wval;
        lcdtt_pkg::REG_TMA:  tma_val = it.wval;
        lcdtt_pkg::REG_TAC:  tac_val = lcdtt_pkg::TAC_FIXED | it.wval;
        lcdtt_pkg::REG_IF:   if_val = lcdtt_pkg::IRQ_FIXED | it.wval;
        lcdtt_pkg::REG_LCDC: begin
          lcdc_val = it.wval;
          if (!lcdc_val[LCDC_ENABLE]) begin
            stat_val[1:0] = lcdtt_pkg::MODE_HBLANK;
            ly_val = 8'd0;
            mode_budget = int'(lcdtt_pkg::MCL_RESET);
          end
        end
        lcdtt_pkg::REG_STAT: stat_val = (stat_val & 8'h83) | (it.wval & 8'hFC);
        lcdtt_pkg::REG_LYC: begin
          lyc_val = it.wval;
          if (ly_val == lyc_val) begin
            stat_val[STAT_MATCH] = 1'b1;
            if (stat_val[STAT_IE_LYC]) if_val[IF_STAT] = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (it.action == lcdtt_pkg::ACT_READ) begin
      case (it.sel)
        lcdtt_pkg::REG_DIV:  r.rval = div_count[15:8];
        lcdtt_pkg::REG_TIMA: r.rval = tima_val;
        lcdtt_pkg::REG_TMA:  r.rval = tma_val;
        lcdtt_pkg::REG_TAC:  r.rval = tac_val;
        lcdtt_pkg::REG_IF:   r.rval = if_val;
        lcdtt_pkg::REG_LCDC: r.rval = lcdc_val;
        lcdtt_pkg::REG_STAT: r.rval = stat_val;
        lcdtt_pkg::REG_LY:   r.rval = ly_val;
        lcdtt_pkg::REG_LYC:  r.rval = lyc_val;
        default:             r.rval = lcdtt_pkg::READ_UNUSED;
      endcase
    end
    r.irq = if_val;
    r.mode = stat_val[1:0];
    r.line = ly_val;
    return r;
  endfunction

  function automatic bus_item_t make_item(logic [1:0] act, logic [3:0] sel, logic [7:0] wval,
                                          logic [7:0] cyc);
    bus_item_t it;
    it.action = act;
    it.sel = sel;
    it.wval = wval;
    it.cyc = cyc;
    return it;
  endfunction

  function automatic bus_item_t random_item(bit keep_display);
    bus_item_t   it;
    int unsigned pick;
    it.action = lcdtt_pkg::ACT_TICK;
    it.sel = 4'($urandom_range(15));
    it.wval = 8'($urandom);
    it.cyc = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < (keep_display ? 92 : 55)) begin
      it.action = lcdtt_pkg::ACT_TICK;
      if (keep_display && $urandom_range(9) != 0) it.cyc = 8'($urandom_range(255, 200));
    end else if (pick < (keep_display ? 96 : 75)) begin
      it.action = lcdtt_pkg::ACT_READ;
      if ($urandom_range(3) != 0) it.sel = 4'($urandom_range(8));
    end else if (pick < (keep_display ? 99 : 95)) begin
      it.action = lcdtt_pkg::ACT_WRITE;
      if ($urandom_range(3) != 0) it.sel = 4'($urandom_range(8));
      if (keep_display && it.sel == lcdtt_pkg::REG_LCDC) it.wval[LCDC_ENABLE] = 1'b1;
    end else begin
      it.action = ACT_NONE;
    end
    return it;
  endfunction

  always @(posedge clk_i) begin : bus_driver
    bus_item_t it;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        it = {action, reg_select, write_value, elapsed_cycles};
        expected_results.push_back(predict_result(it));
        accepted_items++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > NO_IDLE_TAIL && $urandom_range(7) == 0) begin
          send_gap = $urandom_range(14);
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          it = pending_items.pop_front();
          action <= it.action;
          reg_select <= it.sel;
          write_value <= it.wval;
          elapsed_cycles <= it.cyc;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    lcd_result_t got;
    lcd_result_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        got = {read_value, irq_flags, lcd_mode, line_number, hblank_started};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transfer: rd=%h if=%h mode=%0d ly=%0d hb=%b",
                     got.rval, got.irq, got.mode, got.line, got.hb);
        end else begin
          want = expected_results.pop_front();
          if (got.rval !== want.rval || got.irq !== want.irq || got.mode !== want.mode ||
              got.line !== want.line || got.hb !== want.hb) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected rd=%h if=%h mode=%0d ly=%0d hb=%b",
                       want.rval, want.irq, want.mode, want.line, want.hb);
              $display("          got      rd=%h if=%h mode=%0d ly=%0d hb=%b",
                       got.rval, got.irq, got.mode, got.line, got.hb);
            end
          end
        end
      end
      if (long_hold) begin
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (pending_items.size() > NO_IDLE_TAIL && $urandom_range(7) == 0) begin
        hold_left = $urandom_range(14);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // The result side is held off long enough for the block to fill and drop its input ready.
  initial begin : receiver_hold
    wait (accepted_items >= 120);
    @(posedge clk_i);
    long_hold <= 1'b1;
    repeat (64) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  initial begin : watchdog
    #400000;
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    div_count = lcdtt_pkg::COUNTER_RESET;
    tima_val = 8'h00;
    tma_val = 8'h00;
    tac_val = lcdtt_pkg::TAC_RESET;
    reload_pending = 1'b0;
    if_val = lcdtt_pkg::IRQ_RESET;
    lcdc_val = lcdtt_pkg::LCDC_RESET;
    stat_val = lcdtt_pkg::STAT_RESET;
    ly_val = 8'd0;
    lyc_val = 8'd0;
    mode_budget = int'(lcdtt_pkg::MCL_RESET);

    pending_items.push_back(make_item(lcdtt_pkg::ACT_READ, lcdtt_pkg::REG_DIV, 8'h00, 8'h00));
    pending_items.push_back(make_item(lcdtt_pkg::ACT_READ, lcdtt_pkg::REG_TAC, 8'hFF, 8'hFF));
    pending_items.push_back(make_item(lcdtt_pkg::ACT_READ, lcdtt_pkg::REG_IF, 8'h00, 8'h00));
    pending_items.push_back(make_item(lcdtt_pkg::ACT_READ, lcdtt_pkg::REG_LCDC, 8'h00, 8'h00));
    pending_items.push_back(make_item(lcdtt_pkg::ACT_READ, lcdtt_pkg::REG_STAT, 8'h00, 8'h00));
    pending_items.push_back(make_item(lcdtt_pkg::ACT_READ, lcdtt_pkg::REG_LY, 8'h00, 8'h00));
    pending_items.push_back(make_item(lcdtt_pkg::ACT_READ, REG_UNUSED_HI, 8'h00, 8'h00));
    pending_items.push_back(make_item(ACT_NONE, REG_UNUSED_HI, 8'hFF, 8'hFF));
    pending_items.push_back(make_item(lcdtt_pkg::ACT_WRITE, lcdtt_pkg::REG_LY, 8'h55, 8'h00));
    pending_items.push_back(make_item(lcdtt_pkg::ACT_WRITE, REG_UNUSED_LO, 8'hAA, 8'h00));
    pending_items.push_back(make_item(lcdtt_pkg::ACT_WRITE, lcdtt_pkg::REG_TMA, 8'hA5, 8'h00));
    pending_items.push_back(make_item(lcdtt_pkg::ACT_WRITE, lcdtt_pkg::REG_TIMA, 8'hFE, 8'h00));
    pending_items.push_back(make_item(lcdtt_pkg::ACT_WRITE, lcdtt_pkg::REG_TAC, 8'h05, 8'h00));
    pending_items.push_back(make_item(lcdtt_pkg::ACT_TICK, lcdtt_pkg::REG_DIV, 8'h00, 8'hFF));
    pending_items.push_back(make_item(lcdtt_pkg::ACT_WRITE, lcdtt_pkg::REG_TAC, 8'h01, 8'h00));
    pending_items.push_back(make_item(lcdtt_pkg::ACT_TICK, lcdtt_pkg::REG_DIV, 8'h00, 8'h00));
    pending_items.push_back(make_item(lcdtt_pkg::ACT_WRITE, lcdtt_pkg::REG_TAC, 8'h04, 8'h00));
    pending_items.push_back(make_item(lcdtt_pkg::ACT_TICK, lcdtt_pkg::REG_DIV, 8'h00, 8'hFF));
    pending_items.push_back(make_item(lcdtt_pkg::ACT_WRITE, lcdtt_pkg::REG_DIV, 8'hFF, 8'h00));
    pending_items.push_back(make_item(lcdtt_pkg::ACT_WRITE, lcdtt_pkg::REG_IF, 8'h00, 8'h00));
    pending_items.push_back(make_item(lcdtt_pkg::ACT_WRITE, lcdtt_pkg::REG_STAT, 8'hFF, 8'h00));
    pending_items.push_back(make_item(lcdtt_pkg::ACT_WRITE, lcdtt_pkg::REG_LYC, 8'h00, 8'h00));
    pending_items.push_back(make_item(lcdtt_pkg::ACT_WRITE, lcdtt_pkg::REG_LCDC, 8'h00, 8'h00));
    pending_items.push_back(make_item(lcdtt_pkg::ACT_TICK, lcdtt_pkg::REG_DIV, 8'h00, 8'hFF));
    pending_items.push_back(make_item(lcdtt_pkg::ACT_WRITE, lcdtt_pkg::REG_LCDC, 8'h91, 8'h00));
    pending_items.push_back(make_item(lcdtt_pkg::ACT_TICK, lcdtt_pkg::REG_DIV, 8'h00, 8'h00));

    for (int i = 0; i < 290; i++) pending_items.push_back(random_item(1'b1));
    for (int i = 0; i < 90; i++) pending_items.push_back(random_item(1'b0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
